### rtl/assert_macros.svh
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a condition that holds at every clock edge out of reset
`define FDTM_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("fdtm assertion failed");

// an implication checked in the same cycle
`define FDTM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdtm implication failed");

// an implication checked in the next cycle
`define FDTM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdtm next-cycle implication failed");

`else

`define FDTM_ASSERT(label, clk, rst, cond)
`define FDTM_ASSERT_IMP(label, clk, rst, ante, cons)
`define FDTM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/fdtm_pkg.sv
// types, constants and helper functions of the feedback delay two tap mix
package fdtm_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int DELAY_W   = 17;
   localparam int GAIN_W    = 11;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 24;
   localparam int SUM_W     = 25;
   localparam int FRAC_W    = 10;

   localparam logic [GAIN_W-1:0] UNIT         = 11'd1024;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 11'd1024;
   localparam logic [GAIN_W-1:0] SMOOTH_RESET = 11'd819;

   localparam logic [DELAY_W-1:0] MIN_DELAY        = 17'd24;
   localparam logic [DELAY_W-1:0] HALF_RATIO_LIMIT = 17'd768;

   localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 25'sd2047;
   localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -25'sd2048;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_GAIN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_COEFF = 2'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] audio_in;
      logic [DELAY_W-1:0]         delay_samples;
      logic [GAIN_W-1:0]          feedback_amount;
      logic [GAIN_W-1:0]          wet_amount;
      logic                       bypass;
      logic                       freeze;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_first;
      logic signed [SAMPLE_W-1:0] out_second;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ2,
      ST_MULT,
      ST_MIX,
      ST_SMOOTH,
      ST_OUT
   } state_type;

   // limit a gain-like value to one unit
   function automatic logic [GAIN_W-1:0] sat_unit(input logic [GAIN_W-1:0] v);
      return (v > UNIT) ? UNIT : v;
   endfunction

   // clip a wide signed value to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > SAMPLE_MAX) r = SAMPLE_MAX;
      else if (v < SAMPLE_MIN) r = SAMPLE_MIN;
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

### rtl/feedback_delay_two_tap_mix.sv
// Feedback delay line with two taps, wet/dry mixes and one-pole output smoothing.
// The result beat is registered in ST_OUT after ST_READ2, ST_MULT, ST_MIX and ST_SMOOTH.
// No new input beat is taken until the sequencer is back in ST_IDLE; it shares the single
// store read port between both taps and then steps through the multiply stages.
// Reset (synchronous): write index, fill count and filters to zero, gains to defaults;
// unwritten store entries read as zero through the fill count, no clearing pass.
`include "assert_macros.svh"

module feedback_delay_two_tap_mix #(
   parameter int STORE_DEPTH = 131072
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fdtm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fdtm_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [fdtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fdtm_pkg::GAIN_W-1:0]      csr_wr_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [AW:0]   FILL_FULL = (AW+1)'(STORE_DEPTH);
   localparam logic [AW-1:0] WI_LAST   = AW'(STORE_DEPTH - 1);
   localparam int SW = fdtm_pkg::SAMPLE_W;
   localparam int GW = fdtm_pkg::GAIN_W;
   localparam int PW = fdtm_pkg::PROD_W;
   localparam int UW = fdtm_pkg::SUM_W;
   localparam int FW = fdtm_pkg::FRAC_W;

   fdtm_pkg::state_type state_ff, state_in;
   fdtm_pkg::req_type   req_ff;

   logic [GW-1:0] gain_ff, gain_in;
   logic [GW-1:0] coeff_ff, coeff_in;
   logic [AW-1:0] wi_ff, wi_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic signed [SW-1:0] smooth_first_ff, smooth_first_in;
   logic signed [SW-1:0] smooth_second_ff, smooth_second_in;

   logic          accept;
   logic          out_free;
   logic [AW-1:0] addr_first;
   logic [AW-1:0] addr_second;
   logic [AW-1:0] addr2_ff;
   logic          valid1_ff, valid2_ff;

   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [SW-1:0] ram_rd_data;

   logic signed [SW-1:0] tap1_ff, tap1_in;
   logic signed [SW-1:0] tap2_in;
   logic signed [PW-1:0] xprod_ff, xprod_in;
   logic signed [SW-1:0] x_ff, x_in;
   logic signed [PW-1:0] fbprod_ff, fbprod_in;
   logic signed [PW-1:0] xdry_ff, xdry_in;
   logic signed [PW-1:0] tw1_ff, tw1_in;
   logic signed [PW-1:0] tw2_ff, tw2_in;
   logic signed [SW-1:0] fed_in;
   logic signed [SW-1:0] mix1_ff, mix1_in;
   logic signed [SW-1:0] mix2_ff, mix2_in;
   logic signed [PW-1:0] ps1_ff, ps1_in;
   logic signed [PW-1:0] pm1_ff, pm1_in;
   logic signed [PW-1:0] ps2_ff, ps2_in;
   logic signed [PW-1:0] pm2_ff, pm2_in;

   logic [GW-1:0] fb_sat;
   logic [GW-1:0] wet_sat;
   logic [GW-1:0] dry;
   logic [GW-1:0] coeff_rest;

   // handshake
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != fdtm_pkg::ST_IDLE);
   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{out_first: smooth_first_ff, out_second: smooth_second_ff};

   // tap address unit
   fdtm_tap_addr #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_tap_addr (
      .delay_samples (req_data.delay_samples),
      .write_index   (wi_ff),
      .addr_first    (addr_first),
      .addr_second   (addr_second)
   );

   // echo store
   assign ram_rd_en   = accept || (state_ff == fdtm_pkg::ST_READ2);
   assign ram_rd_addr = (state_ff == fdtm_pkg::ST_IDLE) ? addr_first : addr2_ff;
   assign ram_wr_en   = (state_ff == fdtm_pkg::ST_MIX) && !req_ff.freeze;

   fdtm_ram #(
      .WIDTH (SW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wi_ff),
      .wr_data (fed_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fdtm_pkg::ST_IDLE: begin
            if (accept) state_in = fdtm_pkg::ST_READ2;
         end
         fdtm_pkg::ST_READ2:  state_in = fdtm_pkg::ST_MULT;
         fdtm_pkg::ST_MULT:   state_in = fdtm_pkg::ST_MIX;
         fdtm_pkg::ST_MIX:    state_in = fdtm_pkg::ST_SMOOTH;
         fdtm_pkg::ST_SMOOTH: state_in = fdtm_pkg::ST_OUT;
         fdtm_pkg::ST_OUT: begin
            if (out_free) state_in = fdtm_pkg::ST_IDLE;
         end
         default: state_in = fdtm_pkg::ST_IDLE;
      endcase
   end

   // csr writes, unknown indexes ignored
   always_comb begin
      gain_in  = gain_ff;
      coeff_in = coeff_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            fdtm_pkg::CSR_INPUT_GAIN: begin
               gain_in = fdtm_pkg::sat_unit(csr_wr_data);
            end
            fdtm_pkg::CSR_SMOOTHING_COEFF: begin
               coeff_in = fdtm_pkg::sat_unit(csr_wr_data);
            end
            default: begin
            end
         endcase
      end
   end

   // gain-like controls
   assign fb_sat     = fdtm_pkg::sat_unit(req_ff.feedback_amount);
   assign wet_sat    = fdtm_pkg::sat_unit(req_ff.wet_amount);
   assign dry        = fdtm_pkg::UNIT - wet_sat;
   assign coeff_rest = fdtm_pkg::UNIT - coeff_ff;

   // first tap lands, input gain product
   always_comb begin
      tap1_in  = valid1_ff ? $signed(ram_rd_data) : '0;
      xprod_in = PW'(req_ff.audio_in) * PW'($signed({1'b0, gain_ff}));
   end

   // second tap lands, feedback and mix products
   always_comb begin
      tap2_in   = valid2_ff ? $signed(ram_rd_data) : '0;
      x_in      = fdtm_pkg::sat_sample(UW'(xprod_ff >>> FW));
      fbprod_in = PW'(tap1_ff) * PW'($signed({1'b0, fb_sat}));
      xdry_in   = PW'(x_in) * PW'($signed({1'b0, dry}));
      tw1_in    = PW'(tap1_ff) * PW'($signed({1'b0, wet_sat}));
      tw2_in    = PW'(tap2_in) * PW'($signed({1'b0, wet_sat}));
   end

   // feedback sum, store write, wet/dry mix
   always_comb begin
      fed_in = fdtm_pkg::sat_sample(UW'(x_ff) + UW'(fbprod_ff >>> FW));
      if (req_ff.bypass) begin
         mix1_in = x_ff;
         mix2_in = x_ff;
      end else begin
         mix1_in = fdtm_pkg::sat_sample((UW'(xdry_ff) + UW'(tw1_ff)) >>> FW);
         mix2_in = fdtm_pkg::sat_sample((UW'(xdry_ff) + UW'(tw2_ff)) >>> FW);
      end
   end

   // write index and fill count
   always_comb begin
      wi_in   = wi_ff;
      fill_in = fill_ff;
      if (ram_wr_en) begin
         wi_in = (wi_ff == WI_LAST) ? '0 : wi_ff + 1'b1;
         if (fill_ff != FILL_FULL) fill_in = fill_ff + 1'b1;
      end
   end

   // filter products
   always_comb begin
      ps1_in = PW'(smooth_first_ff) * PW'($signed({1'b0, coeff_ff}));
      pm1_in = PW'(mix1_ff) * PW'($signed({1'b0, coeff_rest}));
      ps2_in = PW'(smooth_second_ff) * PW'($signed({1'b0, coeff_ff}));
      pm2_in = PW'(mix2_ff) * PW'($signed({1'b0, coeff_rest}));
   end

   // filter update and result beat
   always_comb begin
      smooth_first_in  = smooth_first_ff;
      smooth_second_in = smooth_second_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      if ((state_ff == fdtm_pkg::ST_OUT) && out_free) begin
         smooth_first_in  = fdtm_pkg::sat_sample((UW'(ps1_ff) + UW'(pm1_ff)) >>> FW);
         smooth_second_in = fdtm_pkg::sat_sample((UW'(ps2_ff) + UW'(pm2_ff)) >>> FW);
         rsp_valid_in     = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= fdtm_pkg::ST_IDLE;
         gain_ff          <= fdtm_pkg::GAIN_RESET;
         coeff_ff         <= fdtm_pkg::SMOOTH_RESET;
         wi_ff            <= '0;
         fill_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         smooth_first_ff  <= '0;
         smooth_second_ff <= '0;
      end else begin
         state_ff         <= state_in;
         gain_ff          <= gain_in;
         coeff_ff         <= coeff_in;
         wi_ff            <= wi_in;
         fill_ff          <= fill_in;
         rsp_valid_ff     <= rsp_valid_in;
         smooth_first_ff  <= smooth_first_in;
         smooth_second_ff <= smooth_second_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_data;
         addr2_ff  <= addr_second;
         valid1_ff <= ({1'b0, addr_first} < fill_ff);
         valid2_ff <= ({1'b0, addr_second} < fill_ff);
      end
      if (state_ff == fdtm_pkg::ST_READ2) begin
         tap1_ff  <= tap1_in;
         xprod_ff <= xprod_in;
      end
      if (state_ff == fdtm_pkg::ST_MULT) begin
         x_ff      <= x_in;
         fbprod_ff <= fbprod_in;
         xdry_ff   <= xdry_in;
         tw1_ff    <= tw1_in;
         tw2_ff    <= tw2_in;
      end
      if (state_ff == fdtm_pkg::ST_MIX) begin
         mix1_ff <= mix1_in;
         mix2_ff <= mix2_in;
      end
      if (state_ff == fdtm_pkg::ST_SMOOTH) begin
         ps1_ff <= ps1_in;
         pm1_ff <= pm1_in;
         ps2_ff <= ps2_in;
         pm2_ff <= pm2_in;
      end
   end

   // checks
   `FDTM_ASSERT_IMP(a_store_write_in_mix, clock, reset, ram_wr_en, state_ff == fdtm_pkg::ST_MIX)
   `FDTM_ASSERT_IMP(a_index_tracks_fill, clock, reset, fill_ff != FILL_FULL, wi_ff == fill_ff[AW-1:0])
   `FDTM_ASSERT_NXT(a_hold_blocked_result, clock, reset, (state_ff == fdtm_pkg::ST_OUT) && !out_free, state_ff == fdtm_pkg::ST_OUT && $stable(rsp_data))

endmodule

### rtl/fdtm_ram.sv
// generic single write port, single read port ram with registered read
module fdtm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fdtm_tap_addr.sv
// delay clamp and circular read addresses of the two taps
module fdtm_tap_addr #(
   parameter int STORE_DEPTH = 131072,
   localparam int AW = $clog2(STORE_DEPTH),
   localparam int CW = (AW > fdtm_pkg::DELAY_W) ? AW : fdtm_pkg::DELAY_W
) (
   input  logic [fdtm_pkg::DELAY_W-1:0] delay_samples,
   input  logic [AW-1:0]                write_index,
   output logic [AW-1:0]                addr_first,
   output logic [AW-1:0]                addr_second
);

   localparam logic [CW-1:0] DELAY_MAX = CW'(STORE_DEPTH - 1);
   localparam logic [CW-1:0] DELAY_MIN = CW'(fdtm_pkg::MIN_DELAY);
   localparam logic [CW-1:0] HALF_LIM  = CW'(fdtm_pkg::HALF_RATIO_LIMIT);
   localparam logic [AW:0]   DEPTH_X   = (AW+1)'(STORE_DEPTH);

   logic [CW-1:0]   delay_ext;
   logic [CW-1:0]   delay_clamped;
   logic [CW+1:0]   delay_triple;
   logic [CW-1:0]   delay_second;
   logic [AW:0]     diff_first;
   logic [AW:0]     diff_second;

   // clamp the main delay into the store
   always_comb begin
      delay_ext = CW'(delay_samples);
      if (delay_ext < DELAY_MIN) begin
         delay_clamped = DELAY_MIN;
      end else if (delay_ext > DELAY_MAX) begin
         delay_clamped = DELAY_MAX;
      end else begin
         delay_clamped = delay_ext;
      end
   end

   // second tap: half the delay for short delays, three quarters otherwise
   always_comb begin
      delay_triple = (CW+2)'(delay_clamped) + (CW+2)'({delay_clamped, 1'b0});
      if (delay_clamped <= HALF_LIM) begin
         delay_second = delay_clamped >> 1;
      end else begin
         delay_second = delay_triple[CW+1:2];
      end
   end

   // step back from the write index with wrap
   always_comb begin
      diff_first  = {1'b0, write_index} - {1'b0, delay_clamped[AW-1:0]};
      diff_second = {1'b0, write_index} - {1'b0, delay_second[AW-1:0]};
      if (diff_first[AW]) begin
         diff_first = diff_first + DEPTH_X;
      end
      if (diff_second[AW]) begin
         diff_second = diff_second + DEPTH_X;
      end
      addr_first  = diff_first[AW-1:0];
      addr_second = diff_second[AW-1:0];
   end

endmodule
